@@ hw/rtl/tccw_pkg.sv @@
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared constants, types and address helper for the text console writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    // screen geometry
    localparam int ROWS       = 25;
    localparam int COLS       = 80;
    localparam int TAB_STOP   = 4;
    localparam int CELL_COUNT = ROWS * COLS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int PHASE_W    = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

    // field widths
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 32;
    localparam int APB_W  = 32;

    localparam logic [CELL_W-1:0] BLANK_WORD = 16'h0F20;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST    = 8'h7E;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_SCROLL,
        S_PUT,
        S_TAB,
        S_READ,
        S_CLEAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic cap_in;
        logic scroll_start;
        logic clear_start;
        logic sweep_wr;
        logic put_write;
        logic newline;
        logic rd_capture;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             scroll_pending;
        logic             is_newline;
        logic             is_tab;
        logic             is_print;
        logic             rd_in_range;
        logic             last_cell;
        logic             last_col;
        logic             tab_last;
    } t_dp_status;

    // store address of displayed row drow, column col (ring of rows)
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] top,
        input logic [ROW_W-1:0] drow,
        input logic [COL_W-1:0] col
    );
        logic [ROW_W:0] sum;
        logic [ROW_W:0] srow;
        sum = {1'b0, top} + {1'b0, drow};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            srow = sum - (ROW_W+1)'(ROWS);
        end else begin
            srow = sum;
        end
        return ADDR_W'(srow) * ADDR_W'(COLS) + ADDR_W'(col);
    endfunction

endpackage

@@ hw/rtl/tccw_ram.sv @@
// ----------------------------------------------------------------------------
// tccw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/tccw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer: walks each command through decode, writes, sweeps and result.
// ----------------------------------------------------------------------------
module tccw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    input  tccw_pkg::t_dp_status i_status,
    output tccw_pkg::t_dp_cmd    o_cmd
);

    tccw_pkg::t_state r_state;
    tccw_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             slot_free;

    assign slot_free = !r_out_valid || i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tccw_pkg::S_INIT: begin
                if (i_status.last_cell) n_state = tccw_pkg::S_IDLE;
            end
            tccw_pkg::S_IDLE: begin
                if (i_s_tvalid) n_state = tccw_pkg::S_DISPATCH;
            end
            tccw_pkg::S_DISPATCH: begin
                case (i_status.cmd)
                    tccw_pkg::CMD_PUT: begin
                        n_state = i_status.scroll_pending ? tccw_pkg::S_SCROLL
                                                          : tccw_pkg::S_PUT;
                    end
                    tccw_pkg::CMD_READ: begin
                        n_state = i_status.rd_in_range ? tccw_pkg::S_READ
                                                       : tccw_pkg::S_DONE;
                    end
                    tccw_pkg::CMD_CLEAR: n_state = tccw_pkg::S_CLEAR;
                    default:             n_state = tccw_pkg::S_DONE;
                endcase
            end
            tccw_pkg::S_SCROLL: begin
                if (i_status.last_col) n_state = tccw_pkg::S_PUT;
            end
            tccw_pkg::S_PUT: begin
                n_state = i_status.is_tab ? tccw_pkg::S_TAB : tccw_pkg::S_DONE;
            end
            tccw_pkg::S_TAB: begin
                if (i_status.tab_last) n_state = tccw_pkg::S_DONE;
            end
            tccw_pkg::S_READ: n_state = tccw_pkg::S_DONE;
            tccw_pkg::S_CLEAR: begin
                if (i_status.last_cell) n_state = tccw_pkg::S_DONE;
            end
            tccw_pkg::S_DONE: begin
                if (slot_free) n_state = tccw_pkg::S_IDLE;
            end
            default: n_state = tccw_pkg::S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            tccw_pkg::S_INIT: o_cmd.sweep_wr = 1'b1;
            tccw_pkg::S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.cap_in = i_s_tvalid;
            end
            tccw_pkg::S_DISPATCH: begin
                o_cmd.scroll_start = (i_status.cmd == tccw_pkg::CMD_PUT)
                                     && i_status.scroll_pending;
                o_cmd.clear_start  = (i_status.cmd == tccw_pkg::CMD_CLEAR);
            end
            tccw_pkg::S_SCROLL: o_cmd.sweep_wr = 1'b1;
            tccw_pkg::S_PUT: begin
                o_cmd.newline   = i_status.is_newline;
                o_cmd.put_write = i_status.is_print;
            end
            tccw_pkg::S_TAB:   o_cmd.put_write  = 1'b1;
            tccw_pkg::S_READ:  o_cmd.rd_capture = 1'b1;
            tccw_pkg::S_CLEAR: o_cmd.sweep_wr   = 1'b1;
            tccw_pkg::S_DONE:  o_cmd.load_out   = slot_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tccw_pkg::S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

@@ hw/rtl/tccw_dp.sv @@
// ----------------------------------------------------------------------------
// tccw_dp
// Datapath: cursor, ring pointer, sweep counter, cell store and result reg.
// ----------------------------------------------------------------------------
module tccw_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tccw_pkg::t_dp_cmd             i_cmd,
    output tccw_pkg::t_dp_status          o_status,
    input  logic [tccw_pkg::IN_W-1:0]     i_s_tdata,
    input  logic                          i_cfg_we,
    input  logic [tccw_pkg::ATTR_W-1:0]   i_cfg_wdata,
    output logic [tccw_pkg::ATTR_W-1:0]   o_attr,
    output logic [tccw_pkg::OUT_W-1:0]    o_m_tdata
);

    // latched item
    logic [tccw_pkg::CMD_W-1:0]   r_cmd,  n_cmd;
    logic [tccw_pkg::CHAR_W-1:0]  r_ch,   n_ch;
    logic [tccw_pkg::ROW_W-1:0]   r_rrow, n_rrow;
    logic [tccw_pkg::COL_W-1:0]   r_rcol, n_rcol;
    logic [tccw_pkg::CELL_W-1:0]  r_word, n_word;
    logic [tccw_pkg::OUT_W-1:0]   r_out,  n_out;

    // console state
    logic [tccw_pkg::ROW_W-1:0]   r_cur_row, n_cur_row;
    logic [tccw_pkg::COL_W-1:0]   r_cur_col, n_cur_col;
    logic [tccw_pkg::PHASE_W-1:0] r_phase,   n_phase;
    logic [tccw_pkg::ROW_W-1:0]   r_top,     n_top;
    logic [tccw_pkg::ATTR_W-1:0]  r_attr,    n_attr;
    logic [tccw_pkg::ADDR_W-1:0]  r_cnt,     n_cnt;
    logic [tccw_pkg::ADDR_W-1:0]  r_base,    n_base;

    logic                         rd_in_range;
    logic                         col_last;
    logic [tccw_pkg::CHAR_W-1:0]  put_char;
    logic                         ram_we;
    logic [tccw_pkg::ADDR_W-1:0]  ram_waddr;
    logic [tccw_pkg::CELL_W-1:0]  ram_wdata;
    logic [tccw_pkg::ADDR_W-1:0]  ram_raddr;
    logic [tccw_pkg::CELL_W-1:0]  ram_rdata;

    assign rd_in_range = (r_rrow < tccw_pkg::ROW_W'(tccw_pkg::ROWS))
                         && (r_rcol < tccw_pkg::COL_W'(tccw_pkg::COLS));
    assign col_last    = (r_cur_col == tccw_pkg::COL_W'(tccw_pkg::COLS - 1));
    assign put_char    = (r_ch == tccw_pkg::CH_TAB) ? tccw_pkg::CH_SPACE : r_ch;

    always_comb begin
        n_cmd     = r_cmd;
        n_ch      = r_ch;
        n_rrow    = r_rrow;
        n_rcol    = r_rcol;
        n_word    = r_word;
        n_out     = r_out;
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        n_phase   = r_phase;
        n_top     = r_top;
        n_attr    = r_attr;
        n_cnt     = r_cnt;
        n_base    = r_base;

        if (i_cfg_we) n_attr = i_cfg_wdata;

        if (i_cmd.cap_in) begin
            n_cmd  = i_s_tdata[1:0];
            n_ch   = i_s_tdata[9:2];
            n_rrow = i_s_tdata[14:10];
            n_rcol = i_s_tdata[21:15];
            n_word = '0;
        end

        // scroll: blank the old top row, which becomes the new bottom row
        if (i_cmd.scroll_start) begin
            n_base    = tccw_pkg::ADDR_W'(r_top) * tccw_pkg::ADDR_W'(tccw_pkg::COLS);
            n_top     = (r_top == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1))
                        ? '0 : r_top + 1'b1;
            n_cur_row = tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1);
            n_cnt     = '0;
        end

        if (i_cmd.clear_start) begin
            n_base = '0;
            n_cnt  = '0;
        end

        if (i_cmd.sweep_wr) n_cnt = r_cnt + 1'b1;

        // advance cursor, wrap at row end
        if (i_cmd.put_write) begin
            if (col_last) begin
                n_cur_col = '0;
                n_cur_row = r_cur_row + 1'b1;
                n_phase   = '0;
            end else begin
                n_cur_col = r_cur_col + 1'b1;
                n_phase   = (r_phase == tccw_pkg::PHASE_W'(tccw_pkg::TAB_STOP - 1))
                            ? '0 : r_phase + 1'b1;
            end
        end

        if (i_cmd.newline) begin
            n_cur_col = '0;
            n_cur_row = r_cur_row + 1'b1;
            n_phase   = '0;
        end

        if (i_cmd.rd_capture) n_word = ram_rdata;

        if (i_cmd.load_out) begin
            n_out = {4'b0, r_cur_col, r_cur_row, r_word};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_phase   <= '0;
            r_top     <= '0;
            r_attr    <= tccw_pkg::ATTR_RESET;
            r_cnt     <= '0;
            r_base    <= '0;
        end else begin
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_phase   <= n_phase;
            r_top     <= n_top;
            r_attr    <= n_attr;
            r_cnt     <= n_cnt;
            r_base    <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_ch   <= n_ch;
        r_rrow <= n_rrow;
        r_rcol <= n_rcol;
        r_word <= n_word;
        r_out  <= n_out;
    end

    // store ports
    assign ram_we    = i_cmd.sweep_wr | i_cmd.put_write;
    assign ram_waddr = i_cmd.sweep_wr ? r_base + r_cnt
                                      : tccw_pkg::cell_addr(r_top, r_cur_row, r_cur_col);
    assign ram_wdata = i_cmd.sweep_wr ? tccw_pkg::BLANK_WORD : {r_attr, put_char};
    assign ram_raddr = rd_in_range ? tccw_pkg::cell_addr(r_top, r_rrow, r_rcol) : '0;

    tccw_ram #(
        .WIDTH (tccw_pkg::CELL_W),
        .DEPTH (tccw_pkg::CELL_COUNT)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_status                = '0;
        o_status.cmd            = r_cmd;
        o_status.scroll_pending = (r_cur_row == tccw_pkg::ROW_W'(tccw_pkg::ROWS));
        o_status.is_newline     = (r_ch == tccw_pkg::CH_NEWLINE);
        o_status.is_tab         = (r_ch == tccw_pkg::CH_TAB);
        o_status.is_print       = (r_ch >= tccw_pkg::CH_SPACE)
                                  && (r_ch <= tccw_pkg::CH_LAST);
        o_status.rd_in_range    = rd_in_range;
        o_status.last_cell      = (r_cnt == tccw_pkg::ADDR_W'(tccw_pkg::CELL_COUNT - 1));
        o_status.last_col       = (r_cnt == tccw_pkg::ADDR_W'(tccw_pkg::COLS - 1));
        o_status.tab_last       = col_last
                                  || (r_phase == tccw_pkg::PHASE_W'(tccw_pkg::TAB_STOP - 1));
    end

    assign o_attr    = r_attr;
    assign o_m_tdata = r_out;

endmodule

@@ hw/rtl/text_console_cursor_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_writer
// 25x80 text console with its own cell store, cursor and scrolling ring.
// ----------------------------------------------------------------------------
// Each item is one command: put character, read cell or clear screen, and it
// returns exactly one item carrying the read cell (zero unless a read) and the
// cursor position afterwards; a cursor row of 25 means a scroll is pending and
// is done by the next put. After reset the block sweeps the 2000-cell store to
// blank with s_tready low; the attribute register can be written during that
// time. An accepted item passes the dispatch state, then: a printable, newline
// or ignored byte the put state; a read the read state (skipped when out of
// range or for the unused command); a tab the put state and then a tab step
// per space written (up to 4); a pending scroll first blanks a row through the
// single write port of the store, one cell per cycle; a clear blanks every cell.
// The next item is accepted in the cycle after its result is loaded.
// The result register lets the next item be accepted while a result still
// waits on the master side; a second result then holds the sequencer until
// the first one is taken.
// ----------------------------------------------------------------------------
module text_console_cursor_writer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave side; i_s_tdata: command[1:0], char_code[9:2], read_row[14:10],
    // read_col[21:15], zero pad[23:22]
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [tccw_pkg::IN_W-1:0]   i_s_tdata,
    // master side; o_m_tdata: cell_word[15:0], cursor_row[20:16],
    // cursor_col[27:21], zero pad[31:28]
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [tccw_pkg::OUT_W-1:0]  o_m_tdata,
    // register port; text_attribute at byte address 0
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [1:0]                  paddr,
    input  logic [tccw_pkg::APB_W-1:0]  pwdata,
    output logic [tccw_pkg::APB_W-1:0]  prdata,
    output logic                        pready
);

    tccw_pkg::t_dp_cmd               dp_cmd;
    tccw_pkg::t_dp_status            dp_status;
    logic                            cfg_we;
    logic [tccw_pkg::ATTR_W-1:0]     attr;

    // one register: every address in the 4-byte window hits text_attribute
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;
    always_comb begin
        prdata = '0;
        if (paddr[1:0] <= 2'd3) begin
            prdata = tccw_pkg::APB_W'(attr);
        end
    end

    tccw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    tccw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (pwdata[tccw_pkg::ATTR_W-1:0]),
        .o_attr      (attr),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

@@ hw/rtl/tccw_checker.sv @@
// ----------------------------------------------------------------------------
// tccw_checker
// Port-level checks on the console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tccw_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_s_tready,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [tccw_pkg::OUT_W-1:0]  o_m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // cursor column always inside the row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[27:21] < tccw_pkg::COL_W'(tccw_pkg::COLS))
        else $error("cursor column out of range");

    // cursor row at most one past the bottom
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[20:16] <= tccw_pkg::ROW_W'(tccw_pkg::ROWS))
        else $error("cursor row out of range");

    // store sweep follows reset: no item taken, no result shown
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready && !o_m_tvalid)
        else $error("item traffic right after reset");

endmodule

bind text_console_cursor_writer tccw_checker u_tccw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the text console writer: every command item is predicted by a
// cycle-free screen model, and each status item the block returns is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import tccw_pkg::*;

    // command 3 has no function in the block; it must change nothing
    localparam logic [CMD_W-1:0] CMD_NONE      = 2'd3;
    // register map
    localparam logic [1:0]       REG_TEXT_ATTR = 2'd0;
    // idle cycles tolerated: init sweep or a clear plus receiver stalls
    localparam int               STALL_LIMIT   = 12000;
    localparam int               PHASES        = 6;
    localparam int               PHASE_ITEMS   = 305;

    // one status item: cell read, cursor row and column after the command
    typedef struct packed {
        logic [CELL_W-1:0] word;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_report;

    // one row of the directed plan; typed rows carry their status literally
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [7:0]        reps;
        logic              typed;
        t_report           lit;
    } t_plan;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [IN_W-1:0]      i_s_tdata  = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [OUT_W-1:0]     o_m_tdata;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [1:0]           paddr      = '0;
    logic [APB_W-1:0]     pwdata     = '0;
    logic [APB_W-1:0]     prdata;
    logic                 pready;

    // screen model: ring of rows, cursor and attribute shadow
    logic [CELL_W-1:0]    screen [0:CELL_COUNT-1];
    int                   crs_row    = 0;
    int                   crs_col    = 0;
    int                   top_line   = 0;
    logic [ATTR_W-1:0]    attr_shadow = ATTR_RESET;

    t_report              due_reports [$];
    int                   error_count  = 0;
    int                   results_seen = 0;
    int                   idle_cycles  = 0;
    int                   burst_left   = 0;

    // receiver stall pattern state
    int                   rx_mode  = 0;
    int                   rx_left  = 0;
    int                   rx_hold  = 0;
    logic                 rx_level = 1'b0;

    t_plan                plan [0:26];

    text_console_cursor_writer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_error(input string what);
        error_count++;
        $display("%0t ERROR %s", $time, what);
    endtask

    // Screen model for one command. Updates the shadow state and returns the
    // status item the block should send back.
    function automatic t_report apply_command(input logic [CMD_W-1:0] cmd,
                                              input logic [CHAR_W-1:0] ch,
                                              input logic [ROW_W-1:0] rrow,
                                              input logic [COL_W-1:0] rcol);
        t_report           rep;
        int                base;
        int                stop;
        int                n_put;
        int                c;
        logic [CHAR_W-1:0] glyph;
        rep   = '0;
        n_put = 0;
        glyph = CH_SPACE;
        case (cmd)
            CMD_PUT: begin
                // a cursor parked below the bottom row scrolls first
                if (crs_row >= ROWS) begin
                    top_line = (top_line + 1) % ROWS;
                    base     = ((top_line + ROWS - 1) % ROWS) * COLS;
                    for (c = 0; c < COLS; c++) begin
                        screen[base + c] = BLANK_WORD;
                    end
                    crs_row = ROWS - 1;
                end
                if (ch == CH_NEWLINE) begin
                    crs_col = 0;
                    crs_row++;
                end else if (ch == CH_TAB) begin
                    // spaces up to the next stop, clipped at the row end
                    stop  = crs_col + TAB_STOP - crs_col % TAB_STOP;
                    n_put = ((stop > COLS) ? COLS : stop) - crs_col;
                end else if (ch >= CH_SPACE && ch <= CH_LAST) begin
                    glyph = ch;
                    n_put = 1;
                end
                for (c = 0; c < n_put; c++) begin
                    screen[((top_line + crs_row) % ROWS) * COLS + crs_col] =
                        {attr_shadow, glyph};
                    crs_col++;
                end
                if (crs_col >= COLS) begin
                    crs_col = 0;
                    crs_row++;
                end
            end
            CMD_READ: begin
                if (rrow < ROWS && rcol < COLS) begin
                    rep.word = screen[((top_line + int'(rrow)) % ROWS) * COLS + int'(rcol)];
                end
            end
            CMD_CLEAR: begin
                // blank ignores the attribute; cursor and pending scroll stay
                for (c = 0; c < CELL_COUNT; c++) begin
                    screen[c] = BLANK_WORD;
                end
            end
            default: begin
            end
        endcase
        rep.row = ROW_W'(crs_row);
        rep.col = COL_W'(crs_col);
        return rep;
    endfunction

    // Send one command item. Entered and left at a falling edge. The sender
    // runs in bursts; a gap opens when the current burst is used up.
    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                            input logic [ROW_W-1:0] rrow, input logic [COL_W-1:0] rcol,
                            input logic typed, input t_report lit);
        t_report rep;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        burst_left--;
        i_s_tdata  <= {2'b00, rcol, rrow, ch, cmd};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        // predict at acceptance, so attribute writes land in item order
        rep = apply_command(cmd, ch, rrow, rcol);
        due_reports.push_back(typed ? lit : rep);
        @(negedge i_clk);
    endtask

    // hold the sender until every status item is back, then a short pause
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (due_reports.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // one register access: setup cycle, then access cycle
    task automatic apb_xfer(input logic wr, input logic [APB_W-1:0] wdata,
                            output logic [APB_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_TEXT_ATTR;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write the attribute and read it back
    task automatic set_attribute(input logic [ATTR_W-1:0] value);
        logic [APB_W-1:0] rd;
        apb_xfer(1'b1, APB_W'(value), rd);
        attr_shadow = value;
        apb_xfer(1'b0, '0, rd);
        if (rd[ATTR_W-1:0] !== value) begin
            report_error($sformatf("attribute reads %h, wrote %h", rd[ATTR_W-1:0], value));
        end
    endtask

    // receiver: switches among always ready, coin toss, mostly stalled and
    // long alternating runs, each kept for a random stretch
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 400);
        end
        rx_left--;
        case (rx_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= 1'($urandom_range(0, 1));
            2: i_m_tready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (rx_hold == 0) begin
                    rx_hold  = $urandom_range(1, 30);
                    rx_level = !rx_level;
                end
                rx_hold--;
                i_m_tready <= rx_level;
            end
        endcase
    end

    // status checker: every accepted status item against the oldest prediction
    always @(posedge i_clk) begin : check_status
        t_report want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (due_reports.size() == 0) begin
                report_error($sformatf("status %h with nothing due", o_m_tdata));
            end else begin
                want = due_reports.pop_front();
                if (o_m_tdata[15:0] !== want.word) begin
                    report_error($sformatf("item %0d: cell_word %h, want %h",
                                           results_seen, o_m_tdata[15:0], want.word));
                end
                if (o_m_tdata[20:16] !== want.row) begin
                    report_error($sformatf("item %0d: cursor_row %0d, want %0d",
                                           results_seen, o_m_tdata[20:16], want.row));
                end
                if (o_m_tdata[27:21] !== want.col) begin
                    report_error($sformatf("item %0d: cursor_col %0d, want %0d",
                                           results_seen, o_m_tdata[27:21], want.col));
                end
                if (o_m_tdata[31:28] !== 4'b0) begin
                    report_error($sformatf("item %0d: pad bits %b", results_seen,
                                           o_m_tdata[31:28]));
                end
            end
        end
    end

    // watchdog: any handshake on either stream or the register port resets it
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [APB_W-1:0]  rd;
        logic [CHAR_W-1:0] ch;
        int                phase;
        int                issued;
        int                quota;
        int                pick;
        int                roll;
        int                n;
        int                k;

        issued = 0;
        for (k = 0; k < CELL_COUNT; k++) begin
            screen[k] = BLANK_WORD;
        end

        // Directed plan, run with the reset attribute. Blank screen reads,
        // out-of-range reads, the dead command, all byte classes, tabs, tab
        // clipped at the row end, a pending scroll seen by read and clear,
        // newline on a pending scroll, then the scroll itself.
        plan = '{
            '{CMD_READ,  8'h00,      5'd0,  7'd0,   8'd1,  1'b1, '{BLANK_WORD, 5'd0, 7'd0}},
            '{CMD_READ,  8'h00,      5'd24, 7'd79,  8'd1,  1'b1, '{BLANK_WORD, 5'd0, 7'd0}},
            '{CMD_READ,  8'h00,      5'd25, 7'd0,   8'd1,  1'b1, '{16'h0000,   5'd0, 7'd0}},
            '{CMD_READ,  8'hFF,      5'd31, 7'd127, 8'd1,  1'b1, '{16'h0000,   5'd0, 7'd0}},
            '{CMD_READ,  8'h00,      5'd0,  7'd80,  8'd1,  1'b1, '{16'h0000,   5'd0, 7'd0}},
            '{CMD_NONE,  8'hFF,      5'd31, 7'd127, 8'd1,  1'b1, '{16'h0000,   5'd0, 7'd0}},
            '{CMD_PUT,   8'h41,      5'd31, 7'd127, 8'd1,  1'b1, '{16'h0000,   5'd0, 7'd1}},
            '{CMD_PUT,   CH_SPACE,   5'd0,  7'd0,   8'd1,  1'b1, '{16'h0000,   5'd0, 7'd2}},
            '{CMD_PUT,   CH_LAST,    5'd0,  7'd0,   8'd1,  1'b1, '{16'h0000,   5'd0, 7'd3}},
            '{CMD_PUT,   8'h1F,      5'd0,  7'd0,   8'd1,  1'b1, '{16'h0000,   5'd0, 7'd3}},
            '{CMD_PUT,   8'h7F,      5'd0,  7'd0,   8'd1,  1'b1, '{16'h0000,   5'd0, 7'd3}},
            '{CMD_PUT,   8'hFF,      5'd0,  7'd0,   8'd1,  1'b1, '{16'h0000,   5'd0, 7'd3}},
            '{CMD_PUT,   8'h00,      5'd0,  7'd0,   8'd1,  1'b1, '{16'h0000,   5'd0, 7'd3}},
            '{CMD_PUT,   CH_TAB,     5'd0,  7'd0,   8'd1,  1'b1, '{16'h0000,   5'd0, 7'd4}},
            '{CMD_PUT,   CH_TAB,     5'd0,  7'd0,   8'd1,  1'b1, '{16'h0000,   5'd0, 7'd8}},
            '{CMD_READ,  8'h00,      5'd0,  7'd0,   8'd1,  1'b1, '{16'h0F41,   5'd0, 7'd8}},
            '{CMD_READ,  8'h00,      5'd0,  7'd2,   8'd1,  1'b1, '{16'h0F7E,   5'd0, 7'd8}},
            '{CMD_PUT,   8'h5A,      5'd0,  7'd0,   8'd71, 1'b0, '0},
            '{CMD_PUT,   CH_TAB,     5'd0,  7'd0,   8'd1,  1'b0, '0},
            '{CMD_READ,  8'h00,      5'd0,  7'd79,  8'd1,  1'b0, '0},
            '{CMD_PUT,   CH_NEWLINE, 5'd0,  7'd0,   8'd24, 1'b0, '0},
            '{CMD_READ,  8'h00,      5'd24, 7'd0,   8'd1,  1'b0, '0},
            '{CMD_CLEAR, 8'h00,      5'd0,  7'd0,   8'd1,  1'b1, '{16'h0000,   5'(ROWS), 7'd0}},
            '{CMD_PUT,   CH_NEWLINE, 5'd0,  7'd0,   8'd1,  1'b1, '{16'h0000,   5'(ROWS), 7'd0}},
            '{CMD_PUT,   8'h21,      5'd0,  7'd0,   8'd1,  1'b1, '{16'h0000,   5'd24, 7'd1}},
            '{CMD_READ,  8'h00,      5'd24, 7'd0,   8'd1,  1'b1, '{16'h0F21,   5'd24, 7'd1}},
            '{CMD_READ,  8'h00,      5'd0,  7'd0,   8'd1,  1'b1, '{BLANK_WORD, 5'd24, 7'd1}}
        };

        // synchronous reset, held low before release
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // attribute reset value; the block may still be sweeping its store
        apb_xfer(1'b0, '0, rd);
        if (rd[ATTR_W-1:0] !== ATTR_RESET) begin
            report_error($sformatf("attribute after reset %h", rd[ATTR_W-1:0]));
        end

        for (k = 0; k < $size(plan); k++) begin
            repeat (plan[k].reps) begin
                push_cmd(plan[k].cmd, plan[k].ch, plan[k].row, plan[k].col,
                         plan[k].typed, plan[k].lit);
            end
        end

        // Random phases, each with its own attribute (both extremes first).
        // Mostly text runs, newlines and reads; some noise bytes, the dead
        // command, rare clears and full drains of the sender.
        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            set_attribute((phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF
                                                              : ATTR_W'($urandom));
            quota = issued + PHASE_ITEMS;
            while (issued < quota) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 160)
                                                    : $urandom_range(1, 30);
                    // a long run stops at the phase quota
                    if (n > quota - issued) begin
                        n = quota - issued;
                    end
                    repeat (n) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 90) begin
                            ch = CHAR_W'($urandom_range(CH_SPACE, CH_LAST));
                        end else if (roll < 97) begin
                            ch = CH_TAB;
                        end else begin
                            ch = CH_NEWLINE;
                        end
                        push_cmd(CMD_PUT, ch, ROW_W'($urandom), COL_W'($urandom), 1'b0, '0);
                        issued++;
                    end
                end else if (pick < 60) begin
                    repeat ($urandom_range(1, 4)) begin
                        push_cmd(CMD_PUT, CH_NEWLINE, ROW_W'($urandom), COL_W'($urandom),
                                 1'b0, '0);
                        issued++;
                    end
                end else if (pick < 80) begin
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 99) < 85) begin
                            push_cmd(CMD_READ, CHAR_W'($urandom),
                                     ROW_W'($urandom_range(0, ROWS - 1)),
                                     COL_W'($urandom_range(0, COLS - 1)), 1'b0, '0);
                        end else begin
                            push_cmd(CMD_READ, CHAR_W'($urandom), ROW_W'($urandom),
                                     COL_W'($urandom), 1'b0, '0);
                        end
                        issued++;
                    end
                end else if (pick < 92) begin
                    if ($urandom_range(0, 1) == 1) begin
                        ch = CHAR_W'($urandom);
                        push_cmd(CMD_PUT, ch, ROW_W'($urandom), COL_W'($urandom), 1'b0, '0);
                        // ignored bytes do not count toward the phase
                        if (ch == CH_NEWLINE || ch == CH_TAB ||
                            (ch >= CH_SPACE && ch <= CH_LAST)) begin
                            issued++;
                        end
                    end else begin
                        push_cmd(CMD_NONE, CHAR_W'($urandom), ROW_W'($urandom),
                                 COL_W'($urandom), 1'b0, '0);
                    end
                end else if (pick < 97) begin
                    wait_drained();
                end else begin
                    push_cmd(CMD_CLEAR, CHAR_W'($urandom), ROW_W'($urandom),
                             COL_W'($urandom), 1'b0, '0);
                    issued++;
                end
            end
        end

        // all stimulus in; wait for the last status, then a quiet tail
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
